@@ hw/rtl/byte_entropy_estimator_assert.svh @@
// Assertion macros for the byte entropy estimator checker.
// Used by bee_checker; needs clk and rst_n in scope.
`ifndef BYTE_ENTROPY_ESTIMATOR_ASSERT_SVH
`define BYTE_ENTROPY_ESTIMATOR_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define BEE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("byte entropy estimator check failed");

// Consequent holds in the cycle after the antecedent.
`define BEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("byte entropy estimator check failed");

`endif

@@ hw/rtl/bee_pkg.sv @@
// Shared constants, types and log2 helpers for the byte entropy estimator.
// No dependencies.
`default_nettype none
package bee_pkg;

  localparam int MAX_LEN  = 65536;
  localparam int BINS     = 256;
  localparam int BIN_AW   = $clog2(BINS);
  localparam int CNT_W    = $clog2(MAX_LEN + 1);
  localparam int P_W      = $clog2(CNT_W);
  localparam int FRAC_W   = 16;
  localparam int LOG_W    = P_W + FRAC_W;
  localparam int PROD_W   = CNT_W + LOG_W;
  localparam int ACC_W    = PROD_W + BIN_AW;
  localparam int DIV_W    = ACC_W;
  localparam int DIVC_W   = $clog2(DIV_W);
  localparam int ENT_W    = 20;
  localparam logic [ENT_W-1:0] ENT_MAX      = 20'd524288;
  localparam logic [ENT_W-1:0] THRESH_RESET = 20'd491520;

  typedef logic [FRAC_W-1:0] frac_rom_t [BINS];

  typedef struct packed {
    logic              byte_rd;
    logic              byte_wr;
    logic              byte_ovf;
    logic              walk_rd;
    logic              clr_wr;
    logic [BIN_AW-1:0] walk_addr;
    logic              div_load;
    logic              div_step;
    logic              finish;
  } bee_cmd_t;

  typedef struct packed {
    logic cnt_full;
    logic pipe_busy;
    logic out_busy;
  } bee_status_t;

  function automatic frac_rom_t frac_rom_build();
    frac_rom_t   rom;
    logic [63:0] y;
    logic [23:0] v;
    logic [24:0] r;
    for (int m = 0; m < BINS; m++) begin
      y = 64'(256 + m) << 22;
      v = '0;
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        v = {v[22:0], 1'b0};
        if (y >= 64'h8000_0000) begin
          v[0] = 1'b1;
          y = y >> 1;
        end
      end
      r = {1'b0, v} + 25'd128;
      rom[m] = r[23:8];
    end
    return rom;
  endfunction

  localparam frac_rom_t FRAC_ROM = frac_rom_build();

  function automatic logic [LOG_W-1:0] log2_q16(input logic [CNT_W-1:0] x);
    logic [P_W-1:0]   p;
    logic [CNT_W-1:0] norm;
    p = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (x[i]) p = P_W'(i);
    end
    norm = x << (P_W'(CNT_W - 1) - p);
    return {p, FRAC_ROM[norm[CNT_W-2 -: 8]]};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bee_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/bee_ctrl.sv @@
// Sequencer for the byte entropy estimator: byte update, bin walk, divide.
// Depends on bee_pkg.
`default_nettype none
module bee_ctrl import bee_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_last_byte,
  output      logic        in_stall,
  input  wire bee_status_t sts,
  output      bee_cmd_t    cmd
);
  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [BIN_AW-1:0] idx_r, idx_nxt;
  logic [DIVC_W-1:0] dcnt_r, dcnt_nxt;
  logic              last_r, last_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    dcnt_nxt      = dcnt_r;
    last_nxt      = last_r;
    in_stall      = 1'b1;
    cmd           = '0;
    cmd.walk_addr = idx_r;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == BIN_AW'(BINS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        idx_nxt  = '0;
        if (in_valid) begin
          if (!sts.cnt_full) begin
            cmd.byte_rd = 1'b1;
            last_nxt    = in_last_byte;
            state_nxt   = ST_UPD;
          end else begin
            cmd.byte_ovf = 1'b1;
            if (in_last_byte) state_nxt = ST_WALK;
          end
        end
      end
      ST_UPD: begin
        cmd.byte_wr = 1'b1;
        state_nxt   = last_r ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk_rd = 1'b1;
        idx_nxt     = idx_r + 1'b1;
        if (idx_r == BIN_AW'(BINS - 1)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.div_load = 1'b1;
          dcnt_nxt     = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DIVC_W'(DIV_W - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      idx_r   <= '0;
      dcnt_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      dcnt_r  <= dcnt_nxt;
      last_r  <= last_nxt;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/bee_datapath.sv @@
// Datapath: histogram RAM, f*log2(f) pipeline, accumulator, divider, result.
// Depends on bee_pkg and bee_ram.
`default_nettype none
module bee_datapath import bee_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire bee_cmd_t         cmd,
  output      bee_status_t      sts,
  input  wire logic [7:0]       in_byte_value,
  input  wire logic             cfg_we,
  input  wire logic [ENT_W-1:0] cfg_wdata,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [ENT_W-1:0] out_entropy_q16,
  output      logic             out_is_encrypted,
  output      logic             out_too_long
);
  logic [CNT_W-1:0]  rd_data;
  logic              ram_we, ram_re;
  logic [BIN_AW-1:0] ram_waddr, ram_raddr;
  logic [CNT_W-1:0]  ram_wdata;

  logic [BIN_AW-1:0] byte_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [ENT_W-1:0]  thr_r;
  logic              v1_r, v2_r, v3_r;
  logic [BIN_AW-1:0] addr1_r;
  logic [CNT_W-1:0]  f2_r;
  logic [LOG_W-1:0]  lg2_r, lgn_r;
  logic [PROD_W-1:0] prod3_r, nl_r;
  logic [ACC_W-1:0]  acc_r;
  logic [DIV_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              ge;
  logic [ACC_W-1:0]  nl_ext;
  logic [ENT_W-1:0]  ent;
  logic              out_valid_r;
  logic [ENT_W-1:0]  ent_r;
  logic              enc_r, long_r;

  assign ram_re    = cmd.byte_rd | cmd.walk_rd;
  assign ram_raddr = cmd.byte_rd ? in_byte_value : cmd.walk_addr;
  assign ram_we    = cmd.byte_wr | cmd.clr_wr | v1_r;
  assign ram_waddr = cmd.byte_wr ? byte_r : (cmd.clr_wr ? cmd.walk_addr : addr1_r);
  assign ram_wdata = cmd.byte_wr ? rd_data + 1'b1 : '0;

  bee_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign nl_ext  = ACC_W'(nl_r);
  assign rem_sh  = {rem_r, num_r[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, cnt_r};
  assign ge      = rem_sh >= {1'b0, cnt_r};
  assign rem_nxt = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign num_nxt = {num_r[DIV_W-2:0], ge};

  always_comb begin
    if (cnt_r == '0) ent = '0;
    else if (num_r > DIV_W'(ENT_MAX)) ent = ENT_MAX;
    else ent = num_r[ENT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      thr_r       <= THRESH_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      v1_r <= cmd.walk_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.byte_rd) cnt_r <= cnt_r + 1'b1;
      if (cmd.byte_ovf) ovf_r <= 1'b1;
      if (v3_r) acc_r <= acc_r + ACC_W'(prod3_r);
      out_valid_r <= cmd.finish | (out_valid_r & out_stall);
      if (cmd.finish) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
        acc_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_rd) byte_r <= in_byte_value;
    addr1_r <= cmd.walk_addr;
    f2_r    <= rd_data;
    lg2_r   <= log2_q16(rd_data);
    prod3_r <= f2_r * lg2_r;
    lgn_r   <= log2_q16(cnt_r);
    nl_r    <= cnt_r * lgn_r;
    if (cmd.div_load) begin
      rem_r <= '0;
      if (nl_ext > acc_r) num_r <= nl_ext - acc_r + ACC_W'(cnt_r >> 1);
      else num_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
    if (cmd.finish) begin
      ent_r  <= ent;
      enc_r  <= ent > thr_r;
      long_r <= ovf_r;
    end
  end

  assign sts.cnt_full  = cnt_r == CNT_W'(MAX_LEN);
  assign sts.pipe_busy = v1_r | v2_r | v3_r;
  assign sts.out_busy  = out_valid_r & out_stall;

  assign out_valid        = out_valid_r;
  assign out_entropy_q16  = ent_r;
  assign out_is_encrypted = enc_r;
  assign out_too_long     = long_r;
endmodule
`default_nettype wire

@@ hw/rtl/byte_entropy_estimator.sv @@
// Top level of the byte entropy estimator: sequencer plus datapath.
// Depends on bee_pkg, bee_ctrl, bee_datapath.
//
//   channel | direction | ports
//   in      | in        | in_valid, in_stall, in_byte_value, in_last_byte
//   out     | out       | out_valid, out_stall, out_entropy_q16, out_is_encrypted,
//           |           | out_too_long
//   cfg     | in        | cfg_we, cfg_wdata (encrypted_threshold)
//
// A counted byte takes a histogram read, then a write back; a byte past MAX_LEN
// only sets the overflow flag. A last byte adds a walk over all 256 bins, a drain
// (3-stage pipeline, then divider load), a restoring divide of DIV_W (46) quotient
// bits and a result step.
// After reset a sweep over all 256 bins zeroes the histogram RAM with in_stall high.
// A result waits in the output register; the next message is taken meanwhile.
`default_nettype none
module byte_entropy_estimator import bee_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [7:0]       in_byte_value,
  input  wire logic             in_last_byte,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [ENT_W-1:0] out_entropy_q16,
  output      logic             out_is_encrypted,
  output      logic             out_too_long,
  input  wire logic             cfg_we,
  input  wire logic [ENT_W-1:0] cfg_wdata
);
  bee_cmd_t    cmd;
  bee_status_t sts;

  bee_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_byte (in_last_byte),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  bee_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_byte_value    (in_byte_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entropy_q16  (out_entropy_q16),
    .out_is_encrypted (out_is_encrypted),
    .out_too_long     (out_too_long)
  );
endmodule
`default_nettype wire

@@ hw/rtl/bee_checker.sv @@
// Port-level checks for the byte entropy estimator, bound to the top level.
// Depends on bee_pkg and byte_entropy_estimator_assert.svh.
`default_nettype none
`include "byte_entropy_estimator_assert.svh"
module bee_checker import bee_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             in_last_byte,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [ENT_W-1:0] out_entropy_q16,
  input wire logic             out_is_encrypted,
  input wire logic             out_too_long
);
  logic in_acc;
  assign in_acc = in_valid & !in_stall;

  `BEE_ASSERT_NOW(a_ent_range, out_valid, out_entropy_q16 <= ENT_MAX)
  `BEE_ASSERT_NOW(a_enc_nonzero, out_valid && out_is_encrypted, out_entropy_q16 != '0)
  `BEE_ASSERT_NEXT(a_last_stalls, in_acc && in_last_byte, in_stall)
  `BEE_ASSERT_NEXT(a_no_early_result, in_acc && !in_last_byte, !$rose(out_valid))
  `BEE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_entropy_q16) && $stable(out_too_long))
endmodule

bind byte_entropy_estimator bee_checker u_bee_checker (.*);
`default_nettype wire
